/* sv/irspr_pkg.sv */
// Shared constants, codes and widths of the phase-rate evaluator.
`default_nettype none

package irspr_pkg;

  // Element limit per vector and the counter that tracks it
  localparam int MaxElements = 64;
  localparam int CntW        = $clog2(MaxElements + 1);

  // Shared multiplier geometry
  localparam int MulW  = 33;
  localparam int ProdW = 2 * MulW;

  // Register reset values
  localparam logic [15:0]        ResetBetaMin  = 16'd13107;
  localparam logic [15:0]        ResetSteepExp = 16'd6554;
  localparam logic signed [15:0] ResetPhaseOff = 16'sd11067;

  // Radians Q3.13 to turn fraction scale, one turn is 2^16
  localparam int TurnScale   = 83443;
  localparam int QuarterTurn = 16384;
  localparam int OneQ16      = 65536;
  localparam int OneQ12      = 4096;

  // Sine polynomial coefficients, highest order last
  localparam int SinC0 = 102944;
  localparam int SinC1 = 42334;
  localparam int SinC2 = 5223;
  localparam int SinC3 = 307;

  // 2^g cubic coefficients
  localparam int ExpC1 = 45559;
  localparam int ExpC2 = 14821;
  localparam int ExpC3 = 5178;

  // log2 fractional-bit counts of the two callers
  localparam int PowFracBits  = 16;
  localparam int RateFracBits = 12;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BETA_MIN     = 2'd0,
    CFG_STEEP_EXP    = 2'd1,
    CFG_PHASE_OFFSET = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

/* sv/irs_phase_rate_evaluator.sv */
// Top level: sequencer and datapath of the reflecting-surface rate evaluator.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | elem_phase, direct_gain, cascade_mag,
//           |           |                           | cascade_phase, last_elem
//   out     | output    | out_valid_o / out_stall_i | rate, invalid
//   cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// in_stall_o is high while an element occupies the block; its time there is set by the
// single shared multiplier (one product per cycle) and by the log2 routine inside the
// power step: a normalize plus sixteen squarings, skipped when k is zero or the base is
// zero. The element that closes a vector runs log2 once more before the result step.
// Reset (rst_ni low, asynchronous) clears the sum, the element count and the output
// valid flag, and loads the register defaults. A stalled result waits in the output
// register; the next element is taken while it waits.
`default_nettype none

module irs_phase_rate_evaluator (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // element channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] elem_phase_i,
  input  wire logic        [15:0] direct_gain_i,
  input  wire logic        [15:0] cascade_mag_i,
  input  wire logic signed [15:0] cascade_phase_i,
  input  wire logic               last_elem_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed      [15:0] rate_o,
  output logic                    invalid_o,
  // register write channel
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic        [1:0]  cfg_index_i,
  input  wire logic        [15:0] cfg_data_i
);

  localparam int MW = irspr_pkg::MulW;
  localparam int CW = irspr_pkg::CntW;

  // One-hot sequencer: most steps consume the last product and issue the next one
  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001,
    ST_ANG  = 20'h00002,  // angle to turn, fold into quadrant
    ST_SZ2  = 20'h00004,  // z squared
    ST_SP1  = 20'h00008,  // polynomial Horner steps
    ST_SP2  = 20'h00010,
    ST_SP3  = 20'h00020,
    ST_SS   = 20'h00040,  // sine or cosine done
    ST_NORM = 20'h00080,  // log2 normalize
    ST_SQ   = 20'h00100,  // log2 squaring iterations
    ST_PEX  = 20'h00200,  // exponent k * -log2(base)
    ST_EX1  = 20'h00400,  // 2^g cubic
    ST_EX2  = 20'h00800,
    ST_EX3  = 20'h01000,
    ST_PWM  = 20'h02000,  // scale power into amplitude range
    ST_BET  = 20'h04000,
    ST_B2   = 20'h08000,  // beta squared
    ST_BM   = 20'h10000,  // beta * magnitude
    ST_T1   = 20'h20000,
    ST_T2   = 20'h40000,  // accumulate
    ST_OUT  = 20'h80000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic        [15:0] bmin_q, kexp_q;
  logic signed [15:0] poff_q;

  // Item registers
  logic signed [15:0] theta_q, cph_q;
  logic        [15:0] gain_q, mag_q;
  logic               last_q;

  // Datapath registers
  logic               pass_q, pass_d;     // 0: amplitude sine, 1: cascade cosine
  logic               lmode_q, lmode_d;   // 0: power log2, 1: rate log2
  logic        [1:0]  quad_q, quad_d;
  logic        [16:0] z_q, z_d;
  logic        [16:0] z2_q, z2_d;
  logic        [31:0] y_q, y_d;
  logic        [4:0]  n_q, n_d;
  logic        [15:0] f_q, f_d;
  logic        [3:0]  itc_q, itc_d;
  logic        [4:0]  ip_q, ip_d;
  logic        [15:0] g_q, g_d;
  logic        [16:0] pw_q, pw_d;
  logic        [16:0] beta_q, beta_d;
  logic        [16:0] b2_q, b2_d;
  logic        [16:0] bm_q, bm_d;
  logic        [16:0] t1_q, t1_d;
  logic signed [17:0] cosv_q, cosv_d;
  logic signed [31:0] sum_q, sum_d;
  logic        [CW-1:0] cnt_q, cnt_d;
  logic signed [15:0] res_rate_q, res_rate_d;
  logic               res_inv_q, res_inv_d;

  // Output register
  logic               out_valid_q;
  logic signed [15:0] out_rate_q;
  logic               out_inv_q;

  // Shared multiplier
  logic signed [MW-1:0]                  mul_a, mul_b;
  logic signed [irspr_pkg::ProdW-1:0]    prod;

  irspr_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Product views and helpers
  logic        [16:0] hi17;
  logic        [17:0] hi18;
  logic        [15:0] ang_u;
  logic        [14:0] ang_rc;
  logic        [16:0] sin_z;
  logic        [16:0] sin_mag;
  logic signed [17:0] sin_val;
  logic        [17:0] base_sum;
  logic        [16:0] base;
  logic        [31:0] ynorm;
  logic               norm_done;
  logic        [4:0]  nnorm;
  logic        [32:0] sq_t;
  logic               sq_bit;
  logic        [31:0] sq_y;
  logic        [15:0] f_new;
  logic signed [6:0]  lexp;
  logic signed [22:0] logv;
  logic signed [22:0] lneg;
  logic signed [22:0] lsh;
  logic signed [15:0] rate_sat;
  logic        [24:0] pex_p;
  logic        [8:0]  pex_ip;
  logic        [15:0] pex_fp;
  logic        [15:0] pex_g;
  logic        [17:0] ex_v;
  logic        [17:0] ex_vs;
  logic        [16:0] ex_pw;
  logic signed [33:0] acc;
  logic signed [31:0] acc_sat;
  logic signed [32:0] xarg;
  logic        [CW-1:0] cnt_inc;
  logic               vec_end;
  logic               in_xfer, out_load;

  assign hi17 = prod[32:16];
  assign hi18 = prod[33:16];

  // Angle product shifted down by 16 bits gives the turn fraction directly in its low bits
  assign ang_u  = prod[31:16] + (pass_q ? 16'(irspr_pkg::QuarterTurn) : 16'd0);
  assign ang_rc = 15'(irspr_pkg::QuarterTurn) - {1'b0, ang_u[13:0]};
  assign sin_z  = ang_u[14] ? {ang_rc, 2'b00} : {1'b0, ang_u[13:0], 2'b00};

  assign sin_mag  = (hi18 > 18'(irspr_pkg::OneQ16)) ? 17'(irspr_pkg::OneQ16) : hi18[16:0];
  assign sin_val  = quad_q[1] ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign base_sum = 18'(sin_val) + 18'(irspr_pkg::OneQ16);
  assign base     = base_sum[17:1];

  // Normalize: bring the leading one to bit 30, eight places at a time while far off
  always_comb begin
    norm_done = 1'b0;
    ynorm     = y_q;
    nnorm     = n_q;
    priority if (y_q[31]) begin
      ynorm     = {1'b0, y_q[31:1]};
      nnorm     = 5'd31;
      norm_done = 1'b1;
    end else if (y_q[30]) begin
      norm_done = 1'b1;
    end else if (y_q[30:23] == 8'd0) begin
      ynorm = {y_q[23:0], 8'd0};
      nnorm = n_q - 5'd8;
    end else begin
      ynorm = {y_q[30:0], 1'b0};
      nnorm = n_q - 5'd1;
    end
  end

  // Squaring step: one result bit per iteration
  assign sq_t   = prod[62:30];
  assign sq_bit = sq_t[31];
  assign sq_y   = sq_bit ? {1'b0, sq_t[31:1]} : sq_t[31:0];

  always_comb begin
    f_new = f_q;
    f_new[4'd15 - itc_q] = sq_bit;
  end

  assign lexp = $signed({2'b00, n_q})
              - (lmode_q ? 7'(irspr_pkg::RateFracBits) : 7'(irspr_pkg::PowFracBits));
  assign logv = $signed({lexp, f_new});
  assign lneg = -logv;
  assign lsh  = logv >>> 6;

  always_comb begin
    if (lsh > 23'sd32767) begin
      rate_sat = 16'sh7FFF;
    end else if (lsh < -23'sd32768) begin
      rate_sat = -16'sh8000;
    end else begin
      rate_sat = lsh[15:0];
    end
  end

  // Power exponent split into integer and fraction
  assign pex_p  = prod[36:12];
  assign pex_ip = pex_p[24:16];
  assign pex_fp = pex_p[15:0];
  assign pex_g  = 16'(17'(irspr_pkg::OneQ16) - {1'b0, pex_fp});

  assign ex_v  = 18'(irspr_pkg::OneQ16) + {1'b0, hi17};
  assign ex_vs = ex_v >> (6'(ip_q) + 6'd1);
  assign ex_pw = (ex_vs > 18'(irspr_pkg::OneQ16)) ? 17'(irspr_pkg::OneQ16) : ex_vs[16:0];

  // Accumulate with saturation at the 32-bit bounds
  assign acc = 34'(sum_q) + $signed({17'd0, t1_q}) + 34'($signed(hi18));

  always_comb begin
    if (acc > 34'sh07FFFFFFF) begin
      acc_sat = 32'sh7FFFFFFF;
    end else if (acc < -34'sh080000000) begin
      acc_sat = -32'sh80000000;
    end else begin
      acc_sat = acc[31:0];
    end
  end

  assign xarg    = 33'(acc_sat) + 33'(irspr_pkg::OneQ12);
  assign cnt_inc = cnt_q + CW'(1);
  assign vec_end = last_q || (cnt_inc == CW'(irspr_pkg::MaxElements));

  // Sequencer and operand selection
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    lmode_d    = lmode_q;
    quad_d     = quad_q;
    z_d        = z_q;
    z2_d       = z2_q;
    y_d        = y_q;
    n_d        = n_q;
    f_d        = f_q;
    itc_d      = itc_q;
    ip_d       = ip_q;
    g_d        = g_q;
    pw_d       = pw_q;
    beta_d     = beta_q;
    b2_d       = b2_q;
    bm_d       = bm_q;
    t1_d       = t1_q;
    cosv_d     = cosv_q;
    sum_d      = sum_q;
    cnt_d      = cnt_q;
    res_rate_d = res_rate_q;
    res_inv_d  = res_inv_q;
    mul_a      = '0;
    mul_b      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // theta minus offset, scaled to turns
          mul_a   = MW'(17'(elem_phase_i) - 17'(poff_q));
          mul_b   = MW'(irspr_pkg::TurnScale);
          pass_d  = 1'b0;
          state_d = ST_ANG;
        end
      end
      ST_ANG: begin
        quad_d  = ang_u[15:14];
        z_d     = sin_z;
        mul_a   = MW'(sin_z);
        mul_b   = MW'(sin_z);
        state_d = ST_SZ2;
      end
      ST_SZ2: begin
        z2_d    = hi17;
        mul_a   = MW'(irspr_pkg::SinC3);
        mul_b   = MW'(hi17);
        state_d = ST_SP1;
      end
      ST_SP1: begin
        mul_a   = MW'(18'(irspr_pkg::SinC2) - {1'b0, hi17});
        mul_b   = MW'(z2_q);
        state_d = ST_SP2;
      end
      ST_SP2: begin
        mul_a   = MW'(18'(irspr_pkg::SinC1) - {1'b0, hi17});
        mul_b   = MW'(z2_q);
        state_d = ST_SP3;
      end
      ST_SP3: begin
        mul_a   = MW'(18'(irspr_pkg::SinC0) - {1'b0, hi17});
        mul_b   = MW'(z_q);
        state_d = ST_SS;
      end
      ST_SS: begin
        if (!pass_q) begin
          priority if (kexp_q == 16'd0) begin
            pw_d    = 17'(irspr_pkg::OneQ16);
            state_d = ST_PWM;
          end else if (base == 17'd0) begin
            pw_d    = 17'd0;
            state_d = ST_PWM;
          end else begin
            y_d     = 32'(base);
            n_d     = 5'd30;
            lmode_d = 1'b0;
            state_d = ST_NORM;
          end
        end else begin
          cosv_d  = sin_val;
          mul_a   = MW'(beta_q);
          mul_b   = MW'(beta_q);
          state_d = ST_B2;
        end
      end
      ST_NORM: begin
        y_d = ynorm;
        n_d = nnorm;
        if (norm_done) begin
          itc_d   = 4'd0;
          f_d     = 16'd0;
          mul_a   = MW'(ynorm);
          mul_b   = MW'(ynorm);
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        y_d   = sq_y;
        f_d   = f_new;
        itc_d = itc_q + 4'd1;
        if (itc_q == 4'd15) begin
          if (!lmode_q) begin
            mul_a   = MW'(kexp_q);
            mul_b   = MW'(lneg[20:0]);
            state_d = ST_PEX;
          end else begin
            res_rate_d = rate_sat;
            res_inv_d  = 1'b0;
            state_d    = ST_OUT;
          end
        end else begin
          mul_a = MW'(sq_y);
          mul_b = MW'(sq_y);
        end
      end
      ST_PEX: begin
        priority if (pex_ip >= 9'd17) begin
          pw_d    = 17'd0;
          state_d = ST_PWM;
        end else if (pex_fp == 16'd0) begin
          pw_d    = 17'(irspr_pkg::OneQ16) >> pex_ip[4:0];
          state_d = ST_PWM;
        end else begin
          g_d     = pex_g;
          ip_d    = pex_ip[4:0];
          mul_a   = MW'(irspr_pkg::ExpC3);
          mul_b   = MW'(pex_g);
          state_d = ST_EX1;
        end
      end
      ST_EX1: begin
        mul_a   = MW'(18'(irspr_pkg::ExpC2) + {1'b0, hi17});
        mul_b   = MW'(g_q);
        state_d = ST_EX2;
      end
      ST_EX2: begin
        mul_a   = MW'(18'(irspr_pkg::ExpC1) + {1'b0, hi17});
        mul_b   = MW'(g_q);
        state_d = ST_EX3;
      end
      ST_EX3: begin
        pw_d    = ex_pw;
        state_d = ST_PWM;
      end
      ST_PWM: begin
        mul_a   = MW'(17'(irspr_pkg::OneQ16) - {1'b0, bmin_q});
        mul_b   = MW'(pw_q);
        state_d = ST_BET;
      end
      ST_BET: begin
        beta_d  = hi17 + {1'b0, bmin_q};
        // cascade phase minus theta, cosine pass
        mul_a   = MW'(17'(cph_q) - 17'(theta_q));
        mul_b   = MW'(irspr_pkg::TurnScale);
        pass_d  = 1'b1;
        state_d = ST_ANG;
      end
      ST_B2: begin
        b2_d    = hi17;
        mul_a   = MW'(beta_q);
        mul_b   = MW'(mag_q);
        state_d = ST_BM;
      end
      ST_BM: begin
        bm_d    = hi17;
        mul_a   = MW'(b2_q);
        mul_b   = MW'(gain_q);
        state_d = ST_T1;
      end
      ST_T1: begin
        t1_d    = hi17;
        mul_a   = MW'(bm_q);
        mul_b   = MW'(cosv_q);
        state_d = ST_T2;
      end
      ST_T2: begin
        if (vec_end) begin
          sum_d = 32'sd0;
          cnt_d = '0;
          if (xarg <= 33'sd0) begin
            res_rate_d = 16'sd0;
            res_inv_d  = 1'b1;
            state_d    = ST_OUT;
          end else begin
            y_d     = xarg[31:0];
            n_d     = 5'd30;
            lmode_d = 1'b1;
            state_d = ST_NORM;
          end
        end else begin
          sum_d   = acc_sat;
          cnt_d   = cnt_inc;
          state_d = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= 32'sd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      bmin_q      <= irspr_pkg::ResetBetaMin;
      kexp_q      <= irspr_pkg::ResetSteepExp;
      poff_q      <= irspr_pkg::ResetPhaseOff;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      // hold the result until the far side takes it
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          irspr_pkg::CFG_BETA_MIN:     bmin_q <= cfg_data_i;
          irspr_pkg::CFG_STEEP_EXP:    kexp_q <= cfg_data_i;
          irspr_pkg::CFG_PHASE_OFFSET: poff_q <= $signed(cfg_data_i);
          default: ;  // drop writes to unknown indexes
        endcase
      end
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      theta_q <= elem_phase_i;
      gain_q  <= direct_gain_i;
      mag_q   <= cascade_mag_i;
      cph_q   <= cascade_phase_i;
      last_q  <= last_elem_i;
    end
    if (out_load) begin
      out_rate_q <= res_rate_q;
      out_inv_q  <= res_inv_q;
    end
    pass_q     <= pass_d;
    lmode_q    <= lmode_d;
    quad_q     <= quad_d;
    z_q        <= z_d;
    z2_q       <= z2_d;
    y_q        <= y_d;
    n_q        <= n_d;
    f_q        <= f_d;
    itc_q      <= itc_d;
    ip_q       <= ip_d;
    g_q        <= g_d;
    pw_q       <= pw_d;
    beta_q     <= beta_d;
    b2_q       <= b2_d;
    bm_q       <= bm_d;
    t1_q       <= t1_d;
    cosv_q     <= cosv_d;
    res_rate_q <= res_rate_d;
    res_inv_q  <= res_inv_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign rate_o      = out_rate_q;
  assign invalid_o   = out_inv_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTH
  // The squaring loop keeps its operand normalized to [1, 2)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ) |-> (y_q[31:30] == 2'b01))
    else $error("log2 operand left normalized range");

  // A non-positive argument reports a zero rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_o) |-> (rate_o == 16'sd0))
    else $error("invalid result carries nonzero rate");

  // An accepted element starts the angle step on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_ANG))
    else $error("accepted element did not start");

  // A new result appears only from the result step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_OUT))
    else $error("result raised outside result step");
`endif

endmodule

`default_nettype wire

/* sv/irspr_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module irspr_mul (
  input  wire logic                                 clk_i,
  input  wire logic signed [irspr_pkg::MulW-1:0]    a_i,
  input  wire logic signed [irspr_pkg::MulW-1:0]    b_i,
  output logic signed      [irspr_pkg::ProdW-1:0]   prod_o
);

  logic signed [irspr_pkg::ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= irspr_pkg::ProdW'(a_i) * irspr_pkg::ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
